[sv/bsst_pkg.sv]
`default_nettype none
package bsst_pkg;

  localparam int CAP_W   = 11;
  localparam int VALUE_W = 32;
  localparam int COUNT_W = 11;
  localparam int GAP_W   = 32;

  typedef logic signed [VALUE_W-1:0] value_t;
  typedef logic        [GAP_W-1:0]   gap_t;
  typedef logic        [COUNT_W-1:0] count_t;
  typedef logic        [CAP_W-1:0]   cap_t;

  localparam logic ST_STORED = 1'b0;
  localparam logic ST_FULL   = 1'b1;

  localparam gap_t GAP_INIT = '1;

  function automatic gap_t gap_of(input value_t a, input value_t b);
    gap_t d;
    d = (a >= b) ? gap_t'(a - b) : gap_t'(b - a);
    return d;
  endfunction

endpackage
`default_nettype wire

[sv/bsst_in_if.sv]
`default_nettype none
interface bsst_in_if;
  logic             valid;
  logic             ready;
  bsst_pkg::value_t value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface
`default_nettype wire

[sv/bsst_out_if.sv]
`default_nettype none
interface bsst_out_if;
  logic             valid;
  logic             ready;
  logic             status;
  bsst_pkg::count_t count;
  logic             spans_valid;
  bsst_pkg::gap_t   shortest;
  bsst_pkg::gap_t   longest;

  modport source (output valid, output status, output count, output spans_valid,
                  output shortest, output longest, input ready);
  modport sink   (input valid, input status, input count, input spans_valid,
                  input shortest, input longest, output ready);
endinterface
`default_nettype wire

[sv/bsst_cfg_if.sv]
`default_nettype none
interface bsst_cfg_if;
  logic           valid;
  logic           ready;
  bsst_pkg::cap_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[sv/bsst_ram.sv]
`default_nettype none
module bsst_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

[sv/bsst_front.sv]
`default_nettype none
module bsst_front (
  input  wire logic             clk,
  input  wire logic             rst_n,
  bsst_in_if.sink               in_ch,
  output logic                  q_valid,
  input  wire logic             q_ready,
  output bsst_pkg::value_t      q_value
);
  import bsst_pkg::*;

  value_t     slot_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] fill_r;
  logic       push;
  logic       pop;

  assign in_ch.ready = (fill_r != 2'd2);
  assign q_valid     = (fill_r != 2'd0);
  assign q_value     = slot_r[rd_ptr_r];

  assign push = in_ch.valid && in_ch.ready;
  assign pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      unique case ({push, pop})
        2'b10:   fill_r <= fill_r + 2'd1;
        2'b01:   fill_r <= fill_r - 2'd1;
        default: fill_r <= fill_r;
      endcase
    end
  end

  // word storage needs no reset
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= in_ch.value;
    end
  end

endmodule
`default_nettype wire

[sv/bsst_back.sv]
`default_nettype none
module bsst_back #(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  bsst_cfg_if.sink                            cfg_ch,
  input  wire logic                           q_valid,
  output logic                                q_ready,
  input  wire bsst_pkg::value_t               q_value,
  bsst_out_if.source                          out_ch,
  output logic                                ram_wr_en,
  output logic [$clog2(MAX_ENTRIES)-1:0]      ram_wr_addr,
  output bsst_pkg::value_t                    ram_wr_data,
  output logic                                ram_rd_en,
  output logic [$clog2(MAX_ENTRIES)-1:0]      ram_rd_addr,
  input  wire bsst_pkg::value_t               ram_rd_data
);
  import bsst_pkg::*;

  localparam int AW    = $clog2(MAX_ENTRIES);
  localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

  typedef enum logic [2:0] {
    S_IDLE, S_SCAN, S_DRAIN, S_FINISH, S_RESULT
  } state_t;

  state_t             state_r;
  cap_t               capacity_r;
  logic [CNT_W-1:0]   held_r;
  value_t             least_r;
  value_t             greatest_r;
  gap_t               best_r;
  value_t             val_r;
  logic               status_r;
  logic [AW-1:0]      addr_r;
  logic               rd_pend_r;
  logic               gap_v_r;
  gap_t               gap_r;

  logic               out_valid_r;
  logic               out_status_r;
  count_t             out_count_r;
  logic               out_spans_r;
  gap_t               out_shortest_r;
  gap_t               out_longest_r;

  logic [CMP_W-1:0]   cap_eff;
  logic               full;
  logic               spans;
  logic               out_free;

  always_comb begin
    cap_eff = (CMP_W'(capacity_r) > CMP_W'(MAX_ENTRIES)) ? CMP_W'(MAX_ENTRIES)
                                                         : CMP_W'(capacity_r);
  end

  assign full     = CMP_W'(held_r) >= cap_eff;
  assign spans    = held_r >= CNT_W'(2);
  assign out_free = !out_valid_r || out_ch.ready;

  assign cfg_ch.ready = 1'b1;
  assign q_ready      = (state_r == S_IDLE);

  assign ram_rd_en   = (state_r == S_SCAN);
  assign ram_rd_addr = addr_r;
  assign ram_wr_en   = (state_r == S_FINISH);
  assign ram_wr_addr = held_r[AW-1:0];
  assign ram_wr_data = val_r;

  assign out_ch.valid       = out_valid_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.count       = out_count_r;
  assign out_ch.spans_valid = out_spans_r;
  assign out_ch.shortest    = out_shortest_r;
  assign out_ch.longest     = out_longest_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      capacity_r  <= '0;
      held_r      <= '0;
      least_r     <= '0;
      greatest_r  <= '0;
      best_r      <= GAP_INIT;
      rd_pend_r   <= 1'b0;
      gap_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        capacity_r <= cfg_ch.data;
      end
      // the result state reloads the register itself when it is free
      if (out_valid_r && out_ch.ready && (state_r != S_RESULT)) begin
        out_valid_r <= 1'b0;
      end

      // compare pipeline: gap of returned word, then fold into best
      rd_pend_r <= (state_r == S_SCAN);
      gap_v_r   <= rd_pend_r;
      if (rd_pend_r) begin
        gap_r <= gap_of(val_r, ram_rd_data);
      end
      if (gap_v_r && (gap_r < best_r)) begin
        best_r <= gap_r;
      end

      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            val_r  <= q_value;
            addr_r <= '0;
            priority if (full) begin
              status_r <= ST_FULL;
              state_r  <= S_RESULT;
            end else if (held_r == '0) begin
              status_r <= ST_STORED;
              state_r  <= S_FINISH;
            end else begin
              status_r <= ST_STORED;
              state_r  <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          addr_r <= addr_r + AW'(1);
          if (CNT_W'(addr_r) == held_r - CNT_W'(1)) begin
            state_r <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!rd_pend_r && !gap_v_r) begin
            state_r <= S_FINISH;
          end
        end
        S_FINISH: begin
          if (held_r == '0) begin
            least_r    <= val_r;
            greatest_r <= val_r;
          end else begin
            if (val_r < least_r) begin
              least_r <= val_r;
            end
            if (val_r > greatest_r) begin
              greatest_r <= val_r;
            end
          end
          held_r  <= held_r + CNT_W'(1);
          state_r <= S_RESULT;
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid_r    <= 1'b1;
            out_status_r   <= status_r;
            out_count_r    <= COUNT_W'(held_r);
            out_spans_r    <= spans;
            out_shortest_r <= spans ? best_r : '0;
            out_longest_r  <= spans ? gap_t'(greatest_r - least_r) : '0;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_held_bound: assert property (@(posedge clk) disable iff (!rst_n)
    held_r <= CNT_W'(MAX_ENTRIES))
    else $error("held count beyond store depth");

  a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |-> (CNT_W'(addr_r) < held_r))
    else $error("scan reads an entry never written");

  a_store_only_when_room: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr_en |-> (CMP_W'(held_r) < cap_eff))
    else $error("store written while set full");

  a_held_changes_on_store: assert property (@(posedge clk) disable iff (!rst_n)
    (held_r != $past(held_r)) |-> $past(state_r == S_FINISH))
    else $error("held count moved outside a store");
`endif

endmodule
`default_nettype wire

[sv/bounded_set_span_tracker_core.sv]
`default_nettype none
// Bounded set span tracker: every word offered on in_ch is a signed 32-bit number that is
// either rejected (set at capacity) or stored, and each word produces exactly one result on
// out_ch with the status, the held count and the shortest and longest pairwise spans. A
// stored word holds the back end while the new number is compared with every held entry at
// one read of the number store per cycle, then while the compare pipeline drains, then for
// the store and the issue of the result; a rejected word goes straight to its result and the
// first word skips the compare. A two-word queue in front lets the next word be taken while
// one is being worked on, and the result register lets the next word start while a result
// still waits. The store needs no clearing after reset. Capacity is to be written on cfg_ch
// only while idle; the block itself does not enforce this. Writing it never clears the set.
module bounded_set_span_tracker_core #(
  parameter int MAX_ENTRIES = 1024
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  bsst_in_if.sink    in_ch,
  bsst_out_if.source out_ch,
  bsst_cfg_if.sink   cfg_ch
);
  import bsst_pkg::*;

  localparam int AW = $clog2(MAX_ENTRIES);

  logic          q_valid;
  logic          q_ready;
  value_t        q_value;
  logic          ram_wr_en;
  logic [AW-1:0] ram_wr_addr;
  value_t        ram_wr_data;
  logic          ram_rd_en;
  logic [AW-1:0] ram_rd_addr;
  value_t        ram_rd_data;

  bsst_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .q_value (q_value)
  );

  bsst_back #(
    .MAX_ENTRIES (MAX_ENTRIES)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_ch      (cfg_ch),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_value     (q_value),
    .out_ch      (out_ch),
    .ram_wr_en   (ram_wr_en),
    .ram_wr_addr (ram_wr_addr),
    .ram_wr_data (ram_wr_data),
    .ram_rd_en   (ram_rd_en),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data)
  );

  bsst_ram #(
    .WIDTH (VALUE_W),
    .DEPTH (MAX_ENTRIES)
  ) u_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule
`default_nettype wire
